// ----- hdl/bhfm_pkg.sv -----
// Shared types and constants of the boxcar hysteresis frequency meter.
package bhfm_pkg;

    localparam int SAMPLE_W    = 16;
    localparam int WORD_W      = 32;
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 88;
    localparam int CFG_IDX_W   = 2;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    localparam logic [CFG_IDX_W-1:0] REG_LOW_THRESHOLD  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HIGH_THRESHOLD = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_RATE     = 2'd2;

    localparam logic signed [SAMPLE_W-1:0] LOW_THRESHOLD_RST  = 16'sd2000;
    localparam logic signed [SAMPLE_W-1:0] HIGH_THRESHOLD_RST = 16'sd3000;
    localparam logic [WORD_W-1:0]          BLOCK_RATE_RST     = 32'd1000;

    localparam logic KIND_INIT  = 1'b0;
    localparam logic KIND_BLOCK = 1'b1;

    typedef struct packed {
        logic                  valid;
        logic [CFG_IDX_W-1:0]  index;
        logic [WORD_W-1:0]     data;
    } cfg_wr_t;

    typedef struct packed {
        logic [WORD_W-1:0]   frequency;
        logic [WORD_W-1:0]   period_blocks;
        logic                period_valid;
        logic                rising_edge;
        logic                level_state;
        logic [SAMPLE_W-1:0] average;
    } result_t;

endpackage

// ----- hdl/bhfm_front.sv -----
// Front part: skips the preamble, sums samples into blocks and queues the work.
module bhfm_front
    import bhfm_pkg::*;
#(
    parameter int AVG_LEN = 10,
    localparam int ACC_W = SAMPLE_W + $clog2(AVG_LEN),
    localparam int CNT_W = (AVG_LEN > 1) ? $clog2(AVG_LEN) : 1
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [SAMPLE_W-1:0] sample,
    output logic                push,
    output logic [ACC_W:0]      push_data,
    input  logic                queue_full
);

    logic [1:0]              pre_cnt_reg;
    logic [CNT_W-1:0]        cnt_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [ACC_W-1:0] acc_next;
    logic signed [ACC_W-1:0] sample_ext;
    logic                    accept;
    logic                    in_preamble;
    logic                    block_done;

    assign in_ready    = !queue_full;
    assign accept      = in_valid && in_ready;
    assign in_preamble = (pre_cnt_reg != 2'd2);
    assign sample_ext  = ACC_W'($signed(sample));
    assign acc_next    = acc_reg + sample_ext;
    assign block_done  = (cnt_reg == CNT_W'(AVG_LEN - 1));

    always_comb
    begin
        push      = 1'b0;
        push_data = {KIND_BLOCK, acc_next};
        if (accept)
        begin
            if (in_preamble)
            begin
                push      = (pre_cnt_reg == 2'd1);
                push_data = {KIND_INIT, sample_ext};
            end
            else
            begin
                push = block_done;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pre_cnt_reg <= 2'd0;
            cnt_reg     <= '0;
            acc_reg     <= '0;
        end
        else if (accept)
        begin
            if (in_preamble)
            begin
                pre_cnt_reg <= pre_cnt_reg + 2'd1;
            end
            else if (block_done)
            begin
                cnt_reg <= '0;
                acc_reg <= '0;
            end
            else
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
                acc_reg <= acc_next;
            end
        end
    end

endmodule

// ----- hdl/bhfm_fifo.sv -----
// Short queue of block sums and the level seed between the front and back parts.
module bhfm_fifo
    import bhfm_pkg::*;
#(
    parameter int WIDTH = 21
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             empty
);

    logic [WIDTH-1:0]  mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic              do_push;
    logic              do_pop;

    assign full     = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + QCNT_W'(1);
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - QCNT_W'(1);
            end
        end
    end

endmodule

// ----- hdl/bhfm_back.sv -----
// Back part: averages a block, runs the hysteresis, measures the period and frequency.
module bhfm_back
    import bhfm_pkg::*;
#(
    parameter int AVG_LEN = 10,
    localparam int ACC_W = SAMPLE_W + $clog2(AVG_LEN),
    localparam int SHIFT = ACC_W + $clog2(AVG_LEN),
    localparam int PROD_W = 2 * ACC_W + 1
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  cfg_wr_t        cfg,
    input  logic           q_empty,
    input  logic [ACC_W:0] q_data,
    output logic           q_pop,
    output logic           out_valid,
    input  logic           out_ready,
    output result_t        result
);

    localparam logic [ACC_W:0] RECIP = (ACC_W + 1)'(((64'd1 << SHIFT) + AVG_LEN - 1) / AVG_LEN);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL  = 3'd1;
    localparam logic [2:0] S_AVG  = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_EMIT = 3'd4;

    logic [2:0]                 state_reg;
    logic signed [SAMPLE_W-1:0] low_reg;
    logic signed [SAMPLE_W-1:0] high_reg;
    logic [WORD_W-1:0]          rate_reg;
    logic                       level_reg;
    logic                       edge_seen_reg;
    logic [WORD_W-1:0]          blocks_reg;
    logic                       out_valid_reg;
    result_t                    result_reg;

    logic                       neg_reg;
    logic [ACC_W-1:0]           mag_reg;
    logic [PROD_W-1:0]          prod_reg;
    logic [SAMPLE_W-1:0]        avg_reg;
    logic                       rise_reg;
    logic                       valid_reg;
    logic [WORD_W-1:0]          period_reg;
    logic [WORD_W:0]            rem_reg;
    logic [WORD_W-1:0]          quo_reg;
    logic [4:0]                 step_reg;

    logic signed [ACC_W-1:0]    q_value;
    logic signed [SAMPLE_W-1:0] seed;
    logic signed [SAMPLE_W+1:0] seed_twice;
    logic signed [SAMPLE_W+1:0] mid_sum;
    logic [PROD_W-1:0]          q_wide;
    logic [SAMPLE_W:0]          q_mag;
    logic signed [SAMPLE_W-1:0] avg_c;
    logic [WORD_W-1:0]          blocks_inc;
    logic                       rise_c;
    logic                       level_mid;
    logic                       level_c;
    logic [WORD_W:0]            rem_shift;
    logic [WORD_W:0]            rem_diff;
    logic                       emit_load;

    assign q_value    = $signed(q_data[ACC_W-1:0]);
    assign seed       = q_data[SAMPLE_W-1:0];
    assign seed_twice = (SAMPLE_W + 2)'(seed) <<< 1;
    assign mid_sum    = (SAMPLE_W + 2)'(low_reg) + (SAMPLE_W + 2)'(high_reg);
    assign q_pop      = (state_reg == S_IDLE) && !q_empty;

    always_comb
    begin
        q_wide     = prod_reg >> SHIFT;
        q_mag      = q_wide[SAMPLE_W:0];
        avg_c      = neg_reg ? SAMPLE_W'((SAMPLE_W + 1)'(0) - q_mag) : q_mag[SAMPLE_W-1:0];
        blocks_inc = (&blocks_reg) ? blocks_reg : blocks_reg + WORD_W'(1);
        rise_c     = !level_reg && (avg_c > high_reg);
        level_mid  = level_reg || rise_c;
        level_c    = level_mid && !(avg_c < low_reg);
        rem_shift  = {rem_reg[WORD_W-1:0], quo_reg[WORD_W-1]};
        rem_diff   = rem_shift - {1'b0, period_reg};
    end

    assign emit_load = (state_reg == S_EMIT) && (!out_valid_reg || out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            low_reg       <= LOW_THRESHOLD_RST;
            high_reg      <= HIGH_THRESHOLD_RST;
            rate_reg      <= BLOCK_RATE_RST;
            level_reg     <= 1'b0;
            edge_seen_reg <= 1'b0;
            blocks_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg.valid)
            begin
                unique case (cfg.index)
                    REG_LOW_THRESHOLD:  low_reg  <= cfg.data[SAMPLE_W-1:0];
                    REG_HIGH_THRESHOLD: high_reg <= cfg.data[SAMPLE_W-1:0];
                    REG_BLOCK_RATE:     rate_reg <= cfg.data;
                    default:            ;
                endcase
            end

            if (emit_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (!q_empty)
                    begin
                        if (q_data[ACC_W] == KIND_INIT)
                        begin
                            level_reg <= (seed_twice > mid_sum);
                        end
                        else
                        begin
                            state_reg <= S_MUL;
                        end
                    end
                end
                S_MUL:
                begin
                    state_reg <= S_AVG;
                end
                S_AVG:
                begin
                    level_reg <= level_c;
                    if (rise_c)
                    begin
                        edge_seen_reg <= 1'b1;
                        blocks_reg    <= '0;
                    end
                    else
                    begin
                        blocks_reg <= blocks_inc;
                    end
                    state_reg <= (rise_c && edge_seen_reg) ? S_DIV : S_EMIT;
                end
                S_DIV:
                begin
                    if (step_reg == '0)
                    begin
                        state_reg <= S_EMIT;
                    end
                end
                S_EMIT:
                begin
                    if (emit_load)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            neg_reg <= q_value[ACC_W-1];
            mag_reg <= q_value[ACC_W-1] ? ACC_W'(-q_value) : ACC_W'(q_value);
        end
        if (state_reg == S_MUL)
        begin
            prod_reg <= PROD_W'(mag_reg) * PROD_W'(RECIP);
        end
        if (state_reg == S_AVG)
        begin
            avg_reg    <= avg_c;
            rise_reg   <= rise_c;
            valid_reg  <= rise_c && edge_seen_reg;
            period_reg <= (rise_c && edge_seen_reg) ? blocks_inc : '0;
            rem_reg    <= '0;
            quo_reg    <= rate_reg;
            step_reg   <= 5'd31;
        end
        if (state_reg == S_DIV)
        begin
            step_reg <= step_reg - 5'd1;
            if (!rem_diff[WORD_W])
            begin
                rem_reg <= rem_diff;
                quo_reg <= {quo_reg[WORD_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_shift;
                quo_reg <= {quo_reg[WORD_W-2:0], 1'b0};
            end
        end
        if (emit_load)
        begin
            result_reg.average       <= avg_reg;
            result_reg.level_state   <= level_reg;
            result_reg.rising_edge   <= rise_reg;
            result_reg.period_valid  <= valid_reg;
            result_reg.period_blocks <= period_reg;
            result_reg.frequency     <= valid_reg ? quo_reg : '0;
        end
    end

    assign out_valid = out_valid_reg;
    assign result    = result_reg;

endmodule

// ----- hdl/boxcar_hysteresis_frequency_meter.sv -----
// Top level of the boxcar hysteresis frequency meter.
//
// Samples enter on the s_axis channel, one per transfer, and the front part takes one
// per cycle while its four-entry queue has room. The first two samples after reset
// are a preamble; the second seeds the comparator level. Then every AVG_LEN samples
// form one block, and each block yields exactly one transfer on the m_axis channel
// carrying the average, the level, the rising edge flag, the period and the frequency.
// A block without a measured period passes through the queue and the back part states
// S_IDLE, S_MUL, S_AVG and S_EMIT into the output register; a rising edge that closes
// a period adds the S_DIV state, where the frequency divider makes one quotient bit
// per cycle. The back part handles one block at a time, so with AVG_LEN samples per
// block the input runs at one sample per cycle only while the back part keeps up;
// otherwise the queue fills and s_axis_tready drops. When the receiver stalls, the
// finished result stays in the output register, the back part holds the next one,
// and the queue absorbs input. Reset clears the counters, the level and the edge
// history and loads the default thresholds and block rate. The cfg channel is always
// ready and should only be written while no block is in flight.
module boxcar_hysteresis_frequency_meter
    import bhfm_pkg::*;
#(
    parameter int AVG_LEN = 10
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // [15:0] sample
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // [15:0] average, [16] level_state, [17] rising_edge, [18] period_valid,
    // [50:19] period_blocks, [82:51] frequency, [87:83] zero
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [WORD_W-1:0]      cfg_data
);

    localparam int ACC_W = SAMPLE_W + $clog2(AVG_LEN);

    logic           push;
    logic [ACC_W:0] push_data;
    logic           queue_full;
    logic           pop;
    logic [ACC_W:0] pop_data;
    logic           queue_empty;
    cfg_wr_t        cfg;
    result_t        result;

    assign cfg_ready = 1'b1;
    assign cfg.valid = cfg_valid && cfg_ready;
    assign cfg.index = cfg_index;
    assign cfg.data  = cfg_data;

    bhfm_front #(
        .AVG_LEN (AVG_LEN)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .sample     (s_axis_tdata[SAMPLE_W-1:0]),
        .push       (push),
        .push_data  (push_data),
        .queue_full (queue_full)
    );

    bhfm_fifo #(
        .WIDTH (ACC_W + 1)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (queue_full),
        .pop       (pop),
        .pop_data  (pop_data),
        .empty     (queue_empty)
    );

    bhfm_back #(
        .AVG_LEN (AVG_LEN)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .q_empty   (queue_empty),
        .q_data    (pop_data),
        .q_pop     (pop),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .result    (result)
    );

    assign m_axis_tdata = {5'd0, result.frequency, result.period_blocks,
                           result.period_valid, result.rising_edge,
                           result.level_state, result.average};

endmodule

// ----- tb/sv/tb_boxcar_hysteresis_frequency_meter.sv -----
// Self-checking testbench of the boxcar hysteresis frequency meter.
module tb_boxcar_hysteresis_frequency_meter;
    import bhfm_pkg::*;

    localparam int AVG_LEN      = 10;
    localparam int DRAIN_CYCLES = 60;
    localparam int HOLD_CYCLES  = 400;
    localparam int QUIET_LIMIT  = 20000;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [WORD_W-1:0]      cfg_data;

    int          low_thr;
    int          high_thr;
    logic [31:0] rate;
    int          preamble_seen;
    int          block_fill;
    int          block_sum;
    logic        level_high;
    logic        edge_seen;
    logic [31:0] blocks_since_edge;

    result_t     expected_blocks[$];
    result_t     got_result;
    result_t     want_result;
    int          mismatches;
    int          quiet_cycles;
    bit          idling_on;
    bit          sink_hold_req;
    int          run_left;
    int          wave_target;

    boxcar_hysteresis_frequency_meter #(
        .AVG_LEN (AVG_LEN)
    ) u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #5 clk = ~clk;

    function automatic void predict_sample(input logic signed [15:0] smp);
        int      s;
        int      mean;
        result_t r;
        s = smp;
        if (preamble_seen < 2)
        begin
            preamble_seen++;
            if (preamble_seen == 2)
                level_high = (2 * s) > (low_thr + high_thr);
            return;
        end
        block_sum += s;
        block_fill++;
        if (block_fill < AVG_LEN)
            return;
        mean = block_sum / AVG_LEN;
        block_sum = 0;
        block_fill = 0;
        if (blocks_since_edge != 32'hFFFF_FFFF)
            blocks_since_edge++;
        r = '0;
        if (!level_high && mean > high_thr)
        begin
            level_high = 1'b1;
            r.rising_edge = 1'b1;
            if (edge_seen)
            begin
                r.period_valid = 1'b1;
                r.period_blocks = blocks_since_edge;
                r.frequency = rate / blocks_since_edge;
            end
            edge_seen = 1'b1;
            blocks_since_edge = '0;
        end
        if (level_high && mean < low_thr)
            level_high = 1'b0;
        r.average = mean[15:0];
        r.level_state = level_high;
        expected_blocks.push_back(r);
    endfunction

    function automatic logic [15:0] next_wave_sample();
        int v;
        if (run_left == 0)
        begin
            run_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                    : $urandom_range(5, 60);
            case ($urandom_range(0, 4))
                0, 1:    wave_target = high_thr + int'($urandom_range(1, 3000));
                2, 3:    wave_target = low_thr - int'($urandom_range(1, 3000));
                default: wave_target = int'($urandom_range(0, 65535)) - 32768;
            endcase
        end
        run_left--;
        if ($urandom_range(0, 19) == 0)
            return 16'($urandom);
        v = wave_target + int'($urandom_range(0, 400)) - 200;
        if (v > 32767)
            v = 32767;
        else if (v < -32768)
            v = -32768;
        return v[15:0];
    endfunction

    task automatic flag_error(input string msg);
        mismatches++;
        if (mismatches <= 10)
            $display("%s", msg);
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
            flag_error($sformatf("%s: expected %0h, got %0h", name, want, got));
    endtask

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got_result = result_t'(m_axis_tdata[82:0]);
            if (expected_blocks.size() == 0)
                flag_error($sformatf("unexpected result transfer, tdata %h", m_axis_tdata));
            else
            begin
                want_result = expected_blocks.pop_front();
                check_field("average", want_result.average, got_result.average);
                check_field("level_state", want_result.level_state, got_result.level_state);
                check_field("rising_edge", want_result.rising_edge, got_result.rising_edge);
                check_field("period_valid", want_result.period_valid,
                            got_result.period_valid);
                check_field("period_blocks", want_result.period_blocks,
                            got_result.period_blocks);
                check_field("frequency", want_result.frequency, got_result.frequency);
                check_field("tdata padding", '0, m_axis_tdata[87:83]);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles == QUIET_LIMIT)
            begin
                $display("boxcar_hysteresis_frequency_meter: mismatch");
                $finish;
            end
        end
    end

    // The receiver: random stall bursts, plus one long hold-off on request.
    initial
    begin
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (sink_hold_req)
            begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                sink_hold_req = 1'b0;
                m_axis_tready <= 1'b1;
            end
            else if (idling_on && $urandom_range(0, 7) == 0)
            begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(negedge clk);
                m_axis_tready <= 1'b1;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    task automatic push_sample(input logic [15:0] smp);
        s_axis_tdata <= smp;
        s_axis_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_axis_tready);
        predict_sample(smp);
        @(negedge clk);
        if (idling_on && $urandom_range(0, 5) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge clk);
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
        cfg_index <= idx;
        cfg_data <= value;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            REG_LOW_THRESHOLD:  low_thr = $signed(value[15:0]);
            REG_HIGH_THRESHOLD: high_thr = $signed(value[15:0]);
            REG_BLOCK_RATE:     rate = value;
            default:            ;
        endcase
        @(negedge clk);
    endtask

    // Waits until every expected block has arrived and the pipeline is empty.
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (expected_blocks.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic load_config(input logic [15:0] lo, input logic [15:0] hi,
                               input logic [31:0] blk_rate);
        settle();
        write_reg(REG_LOW_THRESHOLD, {16'd0, lo});
        write_reg(REG_HIGH_THRESHOLD, {16'd0, hi});
        write_reg(REG_BLOCK_RATE, blk_rate);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_wave(input int count);
        repeat (count) push_sample(next_wave_sample());
    endtask

    // Preamble at the sample extremes, then one falling and one first rising block.
    task automatic test_directed_extremes();
        push_sample(16'h8000);
        push_sample(16'h7FFF);
        repeat (AVG_LEN) push_sample(16'h8000);
        repeat (AVG_LEN) push_sample(16'h7FFF);
    endtask

    task automatic test_narrow_band();
        load_config(16'hFF9C, 16'd100, 32'd1);
        send_wave(140);
    endtask

    task automatic test_crossed_thresholds();
        load_config(16'd1000, 16'hFC18, 32'hFFFF_FFFF);
        send_wave(140);
    endtask

    task automatic test_unreachable_thresholds();
        load_config(16'h8000, 16'h7FFF, 32'd7);
        send_wave(80);
    endtask

    task automatic test_inverted_extremes_zero_rate();
        load_config(16'h7FFF, 16'h8000, 32'd0);
        send_wave(80);
    endtask

    task automatic test_random_settings();
        for (int p = 0; p < 4; p++)
        begin
            if ($urandom_range(0, 1) == 0)
                load_config(16'($urandom), 16'($urandom), $urandom);
            else
                load_config(16'($urandom_range(0, 4000)), 16'($urandom_range(4000, 9000)),
                            $urandom_range(1, 5000));
            if (p == 1)
                sink_hold_req = 1'b1;
            send_wave(70);
        end
    endtask

    task automatic test_steady_tail();
        load_config(16'd2000, 16'd3000, 32'd1000);
        idling_on = 1'b0;
        send_wave(110);
    endtask

    initial
    begin
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        cfg_valid = 1'b0;
        cfg_index = REG_LOW_THRESHOLD;
        cfg_data = '0;
        mismatches = 0;
        quiet_cycles = 0;
        idling_on = 1'b1;
        sink_hold_req = 1'b0;
        run_left = 0;
        wave_target = 0;
        low_thr = 2000;
        high_thr = 3000;
        rate = 32'd1000;
        preamble_seen = 0;
        block_fill = 0;
        block_sum = 0;
        level_high = 1'b0;
        edge_seen = 1'b0;
        blocks_since_edge = '0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_directed_extremes();
        test_narrow_band();
        test_crossed_thresholds();
        test_unreachable_thresholds();
        test_inverted_extremes_zero_rate();
        test_random_settings();
        test_steady_tail();
        settle();

        if (expected_blocks.size() != 0)
            flag_error($sformatf("%0d expected results never arrived",
                                 expected_blocks.size()));
        if (mismatches == 0)
            $display("boxcar_hysteresis_frequency_meter: match");
        else
            $display("boxcar_hysteresis_frequency_meter: mismatch");
        $finish;
    end

endmodule
